/* design/btq_pkg.sv */
package btq_pkg;

  localparam int BUCKETS = 4;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int TIME_BITS = 48;
  localparam int ENTRIES = BUCKETS * SLOTS_PER_BUCKET;
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOT_W = $clog2(SLOTS_PER_BUCKET);
  localparam int CNT_W = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int ENT_W = $clog2(ENTRIES);
  localparam int BKT_CW = $clog2(BUCKETS + 1);

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_CANCEL   = 2'd2,
    KIND_DONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BUCKET = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] duration;
    logic [15:0] callback_tag;
    logic [4:0]  handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [4:0]  entry_handle;
    logic [15:0] fired_tag;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_REG    = 3'd1,
    OP_CANCEL = 3'd2,
    OP_TICK   = 3'd3,
    OP_READ   = 3'd4,
    OP_STEP   = 3'd5,
    OP_CPOP   = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BKT_W-1:0] bkt;
  } dp_cmd_t;

  typedef struct packed {
    logic        reply_valid;
    out_item_t   reply;
    logic        need_walk;
    logic        head_empty;
    logic        head_canceled;
    logic        head_expired;
    logic        cancel_more;
  } dp_status_t;

endpackage

/* design/btq_datapath.sv */
module btq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  btq_pkg::in_item_t  item,
  input  btq_pkg::dp_cmd_t   cmd,
  output btq_pkg::dp_status_t stat
);
  import btq_pkg::*;

  logic [TIME_BITS-1:0] current_time;
  logic [TIME_BITS-1:0] earliest;
  logic [BUCKETS-1:0]   in_use;
  logic [23:0]          blen [BUCKETS];
  logic [SLOT_W-1:0]    head [BUCKETS];
  logic [CNT_W-1:0]     cnt  [BUCKETS];
  logic [ENTRIES-1:0]   canceled;
  logic [TIME_BITS-1:0] dl_mem  [ENTRIES];
  logic [15:0]          tag_mem [ENTRIES];

  logic [TIME_BITS-1:0] rd_dl;
  logic [15:0]          rd_tag;
  logic                 rd_canc;
  logic [ENT_W-1:0]     rd_e;
  logic [BKT_W-1:0]     cbkt;

  logic                 reply_valid, reply_valid_next;
  out_item_t            reply, reply_next;
  logic                 need_walk;
  logic                 cancel_more;

  logic [BKT_CW-1:0]    found, freeb, sel;
  logic [ENT_W-1:0]     wr_e, cur_e;
  logic [TIME_BITS-1:0] new_dl;
  logic [BKT_W-1:0]     hb;
  logic [SLOT_W-1:0]    hs, off;
  logic                 hvalid;
  logic [TIME_BITS-1:0] t_next;
  logic                 reg_room, reg_ok, cpop_go, step_pop;

  always_comb begin
    found = BKT_CW'(BUCKETS);
    freeb = BKT_CW'(BUCKETS);
    for (int b = BUCKETS - 1; b >= 0; b--) begin
      if (in_use[b] && blen[b] == item.duration) found = BKT_CW'(b);
      if (!in_use[b]) freeb = BKT_CW'(b);
    end
    sel = (found != BKT_CW'(BUCKETS)) ? found : freeb;
  end

  assign new_dl = current_time + TIME_BITS'(item.duration);
  assign wr_e = ENT_W'({sel[BKT_W-1:0], SLOT_W'(head[sel[BKT_W-1:0]] +
                SLOT_W'(cnt[sel[BKT_W-1:0]]))});
  assign cur_e = ENT_W'({cmd.bkt, head[cmd.bkt]});
  assign hb = BKT_W'(item.handle >> SLOT_W);
  assign hs = item.handle[SLOT_W-1:0];
  assign off = hs - head[hb];
  assign hvalid = (32'(item.handle) < ENTRIES) && in_use[hb] &&
                  (CNT_W'(off) < cnt[hb]) && !canceled[ENT_W'(item.handle)];
  assign t_next = current_time + TIME_BITS'(1);
  assign reg_room = cnt[sel[BKT_W-1:0]] < CNT_W'(SLOTS_PER_BUCKET);
  assign reg_ok = (sel != BKT_CW'(BUCKETS)) && reg_room;
  assign cpop_go = (cnt[cbkt] != '0) && canceled[ENT_W'({cbkt, head[cbkt]})];
  assign step_pop = (cnt[cmd.bkt] != '0) && (rd_canc || rd_dl <= current_time);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_REG && reg_ok) begin
      dl_mem[wr_e]  <= new_dl;
      tag_mem[wr_e] <= item.callback_tag;
    end
    rd_dl  <= dl_mem[cur_e];
    rd_tag <= tag_mem[cur_e];
    rd_e   <= cur_e;
  end

  assign rd_canc = canceled[rd_e];

  always_comb begin
    reply_valid_next = 1'b0;
    reply_next = '0;
    reply_next.last = 1'b1;
    unique case (cmd.op)
      OP_REG: begin
        reply_valid_next = 1'b1;
        reply_next.kind = KIND_REGISTER;
        if (sel == BKT_CW'(BUCKETS)) reply_next.status = ST_NO_BUCKET;
        else if (!reg_room) reply_next.status = ST_FULL;
        else reply_next.entry_handle = 5'(wr_e);
      end
      OP_CANCEL: if (!hvalid) begin
        reply_valid_next = 1'b1;
        reply_next.kind = KIND_CANCEL;
        reply_next.status = ST_BAD;
      end
      OP_CPOP: if (!cpop_go) begin
        reply_valid_next = 1'b1;
        reply_next.kind = KIND_CANCEL;
      end
      OP_STEP: if (step_pop && !rd_canc) begin
        reply_valid_next = 1'b1;
        reply_next.kind = KIND_FIRED;
        reply_next.entry_handle = 5'(rd_e);
        reply_next.fired_tag = rd_tag;
        reply_next.last = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      earliest <= '1;
      in_use <= '0;
      for (int b = 0; b < BUCKETS; b++) begin
        head[b] <= '0;
        cnt[b] <= '0;
      end
      reply_valid <= 1'b0;
      need_walk <= 1'b0;
      cancel_more <= 1'b0;
      cbkt <= '0;
    end else begin
      reply_valid <= reply_valid_next;
      reply <= reply_next;
      unique case (cmd.op)
        OP_REG: begin
          if (reg_ok) begin
            in_use[sel[BKT_W-1:0]] <= 1'b1;
            blen[sel[BKT_W-1:0]] <= item.duration;
            canceled[wr_e] <= 1'b0;
            cnt[sel[BKT_W-1:0]] <= cnt[sel[BKT_W-1:0]] + CNT_W'(1);
            if (new_dl < earliest) earliest <= new_dl;
          end
        end
        OP_CANCEL: begin
          if (hvalid) begin
            canceled[ENT_W'(item.handle)] <= 1'b1;
            cbkt <= hb;
            cancel_more <= 1'b1;
          end
        end
        OP_CPOP: begin
          if (cpop_go) begin
            head[cbkt] <= head[cbkt] + SLOT_W'(1);
            cnt[cbkt] <= cnt[cbkt] - CNT_W'(1);
          end else begin
            cancel_more <= 1'b0;
          end
        end
        OP_TICK: begin
          current_time <= t_next;
          need_walk <= (earliest <= t_next);
          if (earliest <= t_next) earliest <= '1;
        end
        OP_STEP: begin
          if (step_pop) begin
            head[cmd.bkt] <= head[cmd.bkt] + SLOT_W'(1);
            cnt[cmd.bkt] <= cnt[cmd.bkt] - CNT_W'(1);
          end else if (cnt[cmd.bkt] != '0 && rd_dl < earliest) begin
            earliest <= rd_dl;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.reply_valid = reply_valid;
  assign stat.reply = reply;
  assign stat.need_walk = need_walk;
  assign stat.cancel_more = cancel_more;
  assign stat.head_empty = (cnt[cmd.bkt] == '0);
  assign stat.head_canceled = rd_canc;
  assign stat.head_expired = rd_dl <= current_time;
endmodule

/* design/btq_ctrl.sv */
module btq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  btq_pkg::in_item_t   in_item,
  output btq_pkg::in_item_t   item,
  output logic                out_valid,
  input  logic                out_stall,
  output btq_pkg::out_item_t  out_item,
  output btq_pkg::dp_cmd_t    cmd,
  input  btq_pkg::dp_status_t stat
);
  import btq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_REPLY = 7'b0000100,
    S_WALKC = 7'b0001000,
    S_READ  = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_CPOP  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [BKT_W-1:0] bkt;
  logic out_full;
  logic last_bkt;
  logic advance;

  assign in_stall = (state != S_IDLE) || out_full;
  assign out_valid = out_full;
  assign last_bkt = (32'(bkt) == BUCKETS - 1);
  assign advance = stat.head_empty || !(stat.head_canceled || stat.head_expired);

  always_comb begin
    cmd.op = OP_NONE;
    cmd.bkt = bkt;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && !out_full) begin
        if (in_item.command != CMD_UNUSED) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (item.command)
          CMD_REGISTER: cmd.op = OP_REG;
          CMD_CANCEL: cmd.op = OP_CANCEL;
          default: cmd.op = OP_TICK;
        endcase
        state_next = (item.command == CMD_TICK) ? S_WALKC :
                     (item.command == CMD_CANCEL) ? S_CPOP : S_REPLY;
      end
      S_CPOP: begin
        if (!stat.cancel_more) state_next = S_REPLY;
        else cmd.op = OP_CPOP;
        if (stat.reply_valid) state_next = S_IDLE;
      end
      S_REPLY: state_next = S_IDLE;
      S_WALKC: state_next = stat.need_walk ? S_READ : S_IDLE;
      S_READ: if (!out_full && !stat.reply_valid) begin
        cmd.op = OP_READ;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.op = OP_STEP;
        if (advance && last_bkt) state_next = S_IDLE;
        else state_next = S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bkt <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid && !out_full) item <= in_item;
      if (out_full && !out_stall) out_full <= 1'b0;
      if (stat.reply_valid) begin
        out_full <= 1'b1;
        out_item <= stat.reply;
      end
      if (state == S_WALKC && !stat.need_walk) begin
        out_full <= 1'b1;
        out_item <= '{kind: KIND_DONE, status: ST_OK, entry_handle: '0,
                      fired_tag: '0, last: 1'b1};
      end
      if (state == S_WALKC) bkt <= '0;
      if (state == S_STEP && advance) begin
        if (last_bkt) begin
          out_full <= 1'b1;
          out_item <= '{kind: KIND_DONE, status: ST_OK, entry_handle: '0,
                        fired_tag: '0, last: 1'b1};
        end else bkt <= bkt + BKT_W'(1);
      end
    end
  end
endmodule

/* design/bucketed_timeout_queue_core.sv */
// Bucketed timeout queue: one in-order FIFO of deadlines per distinct duration.
// A register or a rejected cancel registers its result in the execute state, and
// a tick with nothing due loads a done item in the walk check. A valid cancel
// pops each canceled head of its bucket before its reply. When the earliest
// deadline has passed, a tick pops the due or canceled heads of each bucket in
// turn, firing the due ones, ends with a done item, and waits while the output
// register is still held by the consumer. A new transaction is taken only once
// the output register is empty, so no new register is taken before the last
// result has been handed on; an unused command is taken with no result.
module bucketed_timeout_queue_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  btq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output btq_pkg::out_item_t out_item
);
  import btq_pkg::*;

  in_item_t   item;
  dp_cmd_t    cmd;
  dp_status_t stat;

  btq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_item, .item,
    .out_valid, .out_stall, .out_item, .cmd, .stat
  );

  btq_datapath u_dp (
    .clk, .rst, .item, .cmd, .stat
  );
endmodule

/* design/btq_checker.sv */
module btq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input btq_pkg::in_item_t  in_item,
  input btq_pkg::out_item_t out_item,
  input logic               out_valid,
  input logic               out_stall
);
  import btq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("out held");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.command != CMD_UNUSED |=> in_stall)
    else $error("busy after accept");
  a_fire: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_FIRED |-> !out_item.last) else $error("fire last");
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_DONE |-> out_item.last) else $error("done last");
endmodule

bind bucketed_timeout_queue_core btq_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .in_item, .out_item, .out_valid, .out_stall
);
